### src/rcfd_pkg.sv
package rcfd_pkg;

  // Frame layout
  localparam int FRAME_LENGTH = 32;
  localparam int POS_W        = $clog2(FRAME_LENGTH + 1);
  localparam int NUM_CHANNELS = 6;
  localparam int CH_IDX_W     = $clog2(NUM_CHANNELS);
  localparam int CH_END       = 2 + 2 * NUM_CHANNELS;

  localparam logic [7:0] HEADER_0 = 8'h20;
  localparam logic [7:0] HEADER_1 = 8'h40;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THROTTLE_LOW_MAX  = 3'd0,
    CFG_STICK_LOW_LIMIT   = 3'd1,
    CFG_STICK_HIGH_LIMIT  = 3'd2,
    CFG_PITCH_GESTURE_MAX = 3'd3,
    CFG_LAND_THRESHOLD    = 3'd4,
    CFG_MODE_LOW_EDGE     = 3'd5,
    CFG_MODE_HIGH_EDGE    = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ARM_NONE   = 2'd0,
    ARM_ARM    = 2'd1,
    ARM_DISARM = 2'd2
  } arm_req_t;

  typedef enum logic [1:0] {
    FLIGHT_LAND     = 2'd0,
    FLIGHT_POSITION = 2'd1,
    FLIGHT_OFFBOARD = 2'd2,
    FLIGHT_MANUAL   = 2'd3
  } flight_req_t;

  // One completed frame, handed from the byte parser to the command stage
  typedef struct packed {
    logic        ok;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] throttle;
    logic [15:0] yaw;
    logic [15:0] aux1;
    logic [15:0] aux2;
  } frame_rec_t;

endpackage

### src/rc_frame_decoder.sv
// A completed frame is queued, then loaded into the output register as a result.
// Throughput: one byte per cycle; one result per complete frame of 32 bytes.
// Bytes stall only when both entries of the two-frame queue are occupied.
// Reset (rst, synchronous, active high): parser idle awaiting a start byte,
// queue and output empty, thresholds at their default values.
module rc_frame_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             frame_ok,
  output logic signed [10:0]               pitch_cmd,
  output logic signed [10:0]               roll_cmd,
  output logic [9:0]                       throttle_cmd,
  output logic signed [10:0]               yaw_cmd,
  output logic [1:0]                       arm_request,
  output logic [1:0]                       flight_request,
  input  logic                             cfg_we,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rcfd_pkg::*;

  logic       push;
  frame_rec_t push_rec;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  frame_rec_t head_rec;

  // Byte parser: position, header, checksum, channel capture
  rcfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  // Completed frames wait here
  rcfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  // Command stage with threshold registers and output register
  rcfd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .head_valid     (head_valid),
    .head_rec       (head_rec),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_ok       (frame_ok),
    .pitch_cmd      (pitch_cmd),
    .roll_cmd       (roll_cmd),
    .throttle_cmd   (throttle_cmd),
    .yaw_cmd        (yaw_cmd),
    .arm_request    (arm_request),
    .flight_request (flight_request)
  );

endmodule

### src/rcfd_front.sv
module rcfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  input  logic                q_full,
  output logic                push,
  output rcfd_pkg::frame_rec_t push_rec
);
  import rcfd_pkg::*;

  logic [POS_W-1:0]    pos;
  logic [POS_W-1:0]    pos_use;
  logic [POS_W-1:0]    pos_off;
  logic [15:0]         sum;
  logic                header_good;
  logic [7:0]          low_hold;
  logic [15:0]         ch [NUM_CHANNELS];
  logic                accept;
  logic                active;
  logic                ch_we;
  logic [CH_IDX_W-1:0] ch_idx;

  // Hold off input only while the queue cannot take a frame
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // A start flag restarts the frame; otherwise idle bytes are dropped
  assign pos_use = frame_start ? '0 : pos;
  assign active  = frame_start || (pos < POS_W'(FRAME_LENGTH));

  // Channel capture on the high byte of each pair
  assign pos_off = pos_use - POS_W'(2);
  assign ch_idx  = pos_off[CH_IDX_W:1];
  assign ch_we   = accept && active && pos_use[0] &&
                   (pos_use >= POS_W'(2)) && (pos_use < POS_W'(CH_END));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_W'(FRAME_LENGTH);
      sum         <= '0;
      header_good <= 1'b0;
      low_hold    <= '0;
    end else if (accept && active) begin
      pos <= pos_use + POS_W'(1);
      if (pos_use == '0) begin
        header_good <= (rx_byte == HEADER_0);
        sum         <= {8'd0, rx_byte};
      end else if (pos_use < POS_W'(FRAME_LENGTH - 2)) begin
        if (pos_use == POS_W'(1)) begin
          header_good <= header_good && (rx_byte == HEADER_1);
        end
        sum <= sum + {8'd0, rx_byte};
        if (pos_use < POS_W'(CH_END) && !pos_use[0]) begin
          low_hold <= rx_byte;
        end
      end else if (pos_use == POS_W'(FRAME_LENGTH - 2)) begin
        low_hold <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ch_we) begin
      ch[ch_idx] <= {rx_byte, low_hold};
    end
  end

  // Last byte closes the frame: checksum is the complement of the sum
  assign push = accept && active && (pos_use == POS_W'(FRAME_LENGTH - 1));

  always_comb begin
    push_rec.ok       = header_good && ({rx_byte, low_hold} == ~sum);
    push_rec.roll     = ch[0];
    push_rec.pitch    = ch[1];
    push_rec.throttle = ch[2];
    push_rec.yaw      = ch[3];
    push_rec.aux1     = ch[4];
    push_rec.aux2     = ch[5];
  end

endmodule

### src/rcfd_queue.sv
module rcfd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rcfd_pkg::frame_rec_t push_rec,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output rcfd_pkg::frame_rec_t head_rec
);
  import rcfd_pkg::*;

  // Two-entry frame queue between parser and command stage
  frame_rec_t  entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_rec   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

endmodule

### src/rcfd_back.sv
module rcfd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                        head_valid,
  input  rcfd_pkg::frame_rec_t        head_rec,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        frame_ok,
  output logic signed [10:0]          pitch_cmd,
  output logic signed [10:0]          roll_cmd,
  output logic [9:0]                  throttle_cmd,
  output logic signed [10:0]          yaw_cmd,
  output logic [1:0]                  arm_request,
  output logic [1:0]                  flight_request
);
  import rcfd_pkg::*;

  // Threshold registers
  logic [15:0] throttle_low_max;
  logic [15:0] stick_low_limit;
  logic [15:0] stick_high_limit;
  logic [15:0] pitch_gesture_max;
  logic [15:0] land_threshold;
  logic [15:0] mode_low_edge;
  logic [15:0] mode_high_edge;

  logic signed [10:0] pitch_next;
  logic signed [10:0] roll_next;
  logic signed [10:0] yaw_next;
  logic [9:0]         throttle_next;
  arm_req_t           arm_next;
  flight_req_t        flight_next;
  logic               thr_low;
  logic               pitch_ok;

  // 2*(raw-1500) clamped to +-1000; inside the band raw fits in 11 bits
  function automatic logic signed [10:0] scale_axis(input logic [15:0] raw);
    logic [11:0] dbl;
    dbl = {raw[10:0], 1'b0} - 12'd3000;
    if (raw >= 16'd2000) begin
      scale_axis = 11'sd1000;
    end else if (raw <= 16'd1000) begin
      scale_axis = -11'sd1000;
    end else begin
      scale_axis = dbl[10:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      throttle_low_max  <= 16'd1050;
      stick_low_limit   <= 16'd1250;
      stick_high_limit  <= 16'd1750;
      pitch_gesture_max <= 16'd1950;
      land_threshold    <= 16'd1800;
      mode_low_edge     <= 16'd1400;
      mode_high_edge    <= 16'd1600;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THROTTLE_LOW_MAX:  throttle_low_max  <= cfg_data;
        CFG_STICK_LOW_LIMIT:   stick_low_limit   <= cfg_data;
        CFG_STICK_HIGH_LIMIT:  stick_high_limit  <= cfg_data;
        CFG_PITCH_GESTURE_MAX: pitch_gesture_max <= cfg_data;
        CFG_LAND_THRESHOLD:    land_threshold    <= cfg_data;
        CFG_MODE_LOW_EDGE:     mode_low_edge     <= cfg_data;
        CFG_MODE_HIGH_EDGE:    mode_high_edge    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stick scaling, gestures and flight request from the queue head
  always_comb begin
    logic [15:0] thr_off;
    thr_off  = head_rec.throttle - 16'd1000;
    pitch_next = scale_axis(head_rec.pitch);
    roll_next  = scale_axis(head_rec.roll);
    yaw_next   = scale_axis(head_rec.yaw);
    if (head_rec.throttle <= 16'd1000) begin
      throttle_next = '0;
    end else if (head_rec.throttle >= 16'd2000) begin
      throttle_next = 10'd1000;
    end else begin
      throttle_next = thr_off[9:0];
    end

    thr_low  = head_rec.throttle <= throttle_low_max;
    pitch_ok = head_rec.pitch <= pitch_gesture_max;
    if (thr_low && pitch_ok && head_rec.roll < stick_low_limit &&
        head_rec.yaw > stick_high_limit) begin
      arm_next = ARM_ARM;
    end else if (thr_low && pitch_ok && head_rec.roll > stick_high_limit &&
                 head_rec.yaw < stick_low_limit) begin
      arm_next = ARM_DISARM;
    end else begin
      arm_next = ARM_NONE;
    end

    if (head_rec.aux1 > land_threshold) begin
      flight_next = FLIGHT_LAND;
    end else if (head_rec.aux2 < mode_low_edge) begin
      flight_next = FLIGHT_POSITION;
    end else if (head_rec.aux2 < mode_high_edge) begin
      flight_next = FLIGHT_OFFBOARD;
    end else begin
      flight_next = FLIGHT_MANUAL;
    end
  end

  // Output register: reload when empty or being taken
  assign pop = head_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head_valid;
    end
  end

  // Rejected frames carry zeros in every command field
  always_ff @(posedge clk) begin
    if (pop) begin
      frame_ok <= head_rec.ok;
      if (head_rec.ok) begin
        pitch_cmd      <= pitch_next;
        roll_cmd       <= roll_next;
        throttle_cmd   <= throttle_next;
        yaw_cmd        <= yaw_next;
        arm_request    <= arm_next;
        flight_request <= flight_next;
      end else begin
        pitch_cmd      <= '0;
        roll_cmd       <= '0;
        throttle_cmd   <= '0;
        yaw_cmd        <= '0;
        arm_request    <= '0;
        flight_request <= '0;
      end
    end
  end

endmodule

### src/rcfd_checker.sv
module rcfd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             frame_ok,
  input logic signed [10:0]               pitch_cmd,
  input logic signed [10:0]               roll_cmd,
  input logic [9:0]                       throttle_cmd,
  input logic signed [10:0]               yaw_cmd,
  input logic [1:0]                       arm_request,
  input logic [1:0]                       flight_request
);
  import rcfd_pkg::*;

  // No result directly after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame_ok) &&
    $stable(pitch_cmd) && $stable(throttle_cmd) && $stable(arm_request))
    else $error("stalled result changed");

  // Rejected frames carry no commands
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_ok |-> pitch_cmd == '0 && roll_cmd == '0 &&
    yaw_cmd == '0 && throttle_cmd == '0 && arm_request == ARM_NONE &&
    flight_request == FLIGHT_LAND)
    else $error("rejected frame with nonzero commands");

  // Commands stay within their clamp ranges
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pitch_cmd <= 11'sd1000 && pitch_cmd >= -11'sd1000 &&
    roll_cmd <= 11'sd1000 && roll_cmd >= -11'sd1000 &&
    yaw_cmd <= 11'sd1000 && yaw_cmd >= -11'sd1000 && throttle_cmd <= 10'd1000)
    else $error("command outside clamp range");

  // Gesture code is never the unused one
  a_arm_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> arm_request != 2'd3)
    else $error("undefined gesture code");

endmodule

bind rc_frame_decoder rcfd_checker u_rcfd_checker (.*);

### verif/rc_frame_checker.sv
module rc_frame_checker
  import rcfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic [7:0]             rx_byte,
  input  logic                   frame_start,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic                   frame_ok,
  input  logic signed [10:0]     pitch_cmd,
  input  logic signed [10:0]     roll_cmd,
  input  logic [9:0]             throttle_cmd,
  input  logic signed [10:0]     yaw_cmd,
  input  logic [1:0]             arm_request,
  input  logic [1:0]             flight_request,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output int                     frames_checked,
  output int                     frames_rejected
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_LIMITS = 7;
  localparam logic [NUM_LIMITS-1:0][15:0] LIMIT_RESET = {
    16'd1600, 16'd1400, 16'd1800, 16'd1950, 16'd1750, 16'd1250, 16'd1050
  };

  typedef struct packed {
    logic               ok;
    logic signed [10:0] pitch;
    logic signed [10:0] roll;
    logic [9:0]         throttle;
    logic signed [10:0] yaw;
    arm_req_t           arm;
    flight_req_t        flight;
  } rc_cmd_t;

  // decoded commands still owed by the block, oldest first
  rc_cmd_t cmd_due [$];

  // shadow of the thresholds and the byte parser
  logic [NUM_LIMITS-1:0][15:0]   limit_q;
  int unsigned                   byte_pos;
  logic [15:0]                   sum_acc;
  logic                          hdr_seen;
  logic [7:0]                    low_hold;
  logic [NUM_CHANNELS-1:0][15:0] chan_val;

  // 2*(raw-1500), clamped to +-1000
  function automatic logic signed [10:0] axis_cmd(input logic [15:0] raw);
    int v;
    v = 2 * (int'(raw) - 1500);
    if (v > 1000) v = 1000;
    if (v < -1000) v = -1000;
    return v[10:0];
  endfunction

  // command for a completed frame, from the captured channels
  function automatic rc_cmd_t decode_frame(input logic [15:0] chk);
    rc_cmd_t r;
    int      t;
    logic    thr_low;
    logic    pitch_ok;
    logic [15:0] roll, pitch, thr, yaw, aux1, aux2;
    r = '0;
    if (!(hdr_seen && chk == 16'hFFFF - sum_acc)) return r;
    roll  = chan_val[0];
    pitch = chan_val[1];
    thr   = chan_val[2];
    yaw   = chan_val[3];
    aux1  = chan_val[4];
    aux2  = chan_val[5];

    t = int'(thr) - 1000;
    if (t < 0) t = 0;
    if (t > 1000) t = 1000;

    thr_low  = thr <= limit_q[CFG_THROTTLE_LOW_MAX];
    pitch_ok = pitch <= limit_q[CFG_PITCH_GESTURE_MAX];
    r.arm = ARM_NONE;
    if (thr_low && pitch_ok && roll < limit_q[CFG_STICK_LOW_LIMIT] &&
        yaw > limit_q[CFG_STICK_HIGH_LIMIT])
      r.arm = ARM_ARM;
    else if (thr_low && pitch_ok && roll > limit_q[CFG_STICK_HIGH_LIMIT] &&
             yaw < limit_q[CFG_STICK_LOW_LIMIT])
      r.arm = ARM_DISARM;

    if (aux1 > limit_q[CFG_LAND_THRESHOLD])
      r.flight = FLIGHT_LAND;
    else if (aux2 < limit_q[CFG_MODE_LOW_EDGE])
      r.flight = FLIGHT_POSITION;
    else if (aux2 < limit_q[CFG_MODE_HIGH_EDGE])
      r.flight = FLIGHT_OFFBOARD;
    else
      r.flight = FLIGHT_MANUAL;

    r.ok       = 1'b1;
    r.pitch    = axis_cmd(pitch);
    r.roll     = axis_cmd(roll);
    r.throttle = t[9:0];
    r.yaw      = axis_cmd(yaw);
    return r;
  endfunction

  // advance the parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b, input logic s);
    int unsigned p;
    if (s)
      byte_pos = 0;
    else if (byte_pos >= FRAME_LENGTH)
      return;  // idle, byte ignored
    p = byte_pos;
    byte_pos = p + 1;
    if (p == 0) begin
      hdr_seen = (b == HEADER_0);
      sum_acc  = {8'h00, b};
    end else if (p < FRAME_LENGTH - 2) begin
      if (p == 1) hdr_seen = hdr_seen && (b == HEADER_1);
      sum_acc = sum_acc + {8'h00, b};
      if (p >= 2 && p < CH_END) begin
        if (p % 2 == 0)
          low_hold = b;
        else
          chan_val[(p - 2) / 2] = {b, low_hold};
      end
    end else if (p == FRAME_LENGTH - 2) begin
      low_hold = b;
    end else begin
      cmd_due.push_back(decode_frame({b, low_hold}));
    end
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin : monitor
    rc_cmd_t want;
    if (rst) begin
      limit_q  = LIMIT_RESET;
      byte_pos = FRAME_LENGTH;
      sum_acc  = '0;
      hdr_seen = 1'b0;
      low_hold = '0;
      chan_val = '0;
      cmd_due.delete();
      fail_count      = 0;
      frames_checked  = 0;
      frames_rejected = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cmd_due.size() == 0) begin
          $error("result transaction with nothing expected (frame_ok %0d)", frame_ok);
          fail_count++;
        end else begin
          want = cmd_due.pop_front();
          check_field("frame_ok", want.ok, frame_ok);
          check_field("pitch_cmd", want.pitch, pitch_cmd);
          check_field("roll_cmd", want.roll, roll_cmd);
          check_field("throttle_cmd", want.throttle, throttle_cmd);
          check_field("yaw_cmd", want.yaw, yaw_cmd);
          check_field("arm_request", want.arm, arm_request);
          check_field("flight_request", want.flight, flight_request);
          frames_checked++;
          if (!want.ok) frames_rejected++;
        end
      end
      if (cfg_we && cfg_index < NUM_LIMITS) limit_q[cfg_index] = cfg_data;
      if (in_valid && !in_stall) parse_byte(rx_byte, frame_start);
    end
    pending = cmd_due.size();
  end

endmodule

### verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rcfd_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 400;
  localparam int BYTES_PER_PHASE = 96;
  localparam int NUM_PHASES      = 6;

  typedef logic [NUM_CHANNELS-1:0][15:0] sticks_t;
  typedef logic [6:0][15:0]              limits_t;
  typedef enum int {FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_SUM, FLAW_SHORT} flaw_t;

  localparam limits_t LIMIT_DEFAULT = {
    16'd1600, 16'd1400, 16'd1800, 16'd1950, 16'd1750, 16'd1250, 16'd1050
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             rx_byte = '0;
  logic                   frame_start = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   frame_ok;
  logic signed [10:0]     pitch_cmd;
  logic signed [10:0]     roll_cmd;
  logic [9:0]             throttle_cmd;
  logic signed [10:0]     yaw_cmd;
  logic [1:0]             arm_request;
  logic [1:0]             flight_request;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int fail_count;
  int pending;
  int frames_checked;
  int frames_rejected;

  int      cycle_cnt = 0;
  int      src_idle_pct = 32;
  int      snk_idle_pct = 54;
  logic    hold_go = 1'b0;
  logic    hold_go_q = 1'b0;
  int      hold_left = 0;
  int      frame_bytes = 0;
  int      whole_frames = 0;
  limits_t cur_cfg = LIMIT_DEFAULT;

  rc_frame_decoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_ok       (frame_ok),
    .pitch_cmd      (pitch_cmd),
    .roll_cmd       (roll_cmd),
    .throttle_cmd   (throttle_cmd),
    .yaw_cmd        (yaw_cmd),
    .arm_request    (arm_request),
    .flight_request (flight_request),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  rc_frame_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .frame_start     (frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_ok        (frame_ok),
    .pitch_cmd       (pitch_cmd),
    .roll_cmd        (roll_cmd),
    .throttle_cmd    (throttle_cmd),
    .yaw_cmd         (yaw_cmd),
    .arm_request     (arm_request),
    .flight_request  (flight_request),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .frames_checked  (frames_checked),
    .frames_rejected (frames_rejected)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    hold_go_q <= hold_go;
    if (hold_go && !hold_go_q)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
    out_stall <= (hold_go && !hold_go_q) || (hold_left > 1) ||
                 ($urandom_range(99) < snk_idle_pct);
  end

  // threshold plus an offset in [lo, hi], kept in 16 bits
  function automatic logic [15:0] shifted(input logic [15:0] th, input int lo, input int hi);
    int v;
    v = int'(th) + lo + int'($urandom_range(hi - lo));
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  function automatic logic [15:0] any_chan(input logic [15:0] th);
    case ($urandom_range(4))
      0: return 16'($urandom_range(16'hFFFF));
      1: return 16'($urandom_range(2100, 880));
      2: return shifted(th, -2, 2);
      3: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return shifted(16'(1000 + 500 * $urandom_range(2)), -3, 3);
    endcase
  endfunction

  // stick set aimed at the current thresholds: arm, disarm or loose
  function automatic sticks_t random_sticks();
    logic [15:0] roll, pitch, thr, yaw, aux1, aux2;
    logic [15:0] lo_lim, hi_lim;
    int          g;
    lo_lim = cur_cfg[CFG_STICK_LOW_LIMIT];
    hi_lim = cur_cfg[CFG_STICK_HIGH_LIMIT];
    g = $urandom_range(5);
    if (g == 0) begin
      thr   = shifted(cur_cfg[CFG_THROTTLE_LOW_MAX], -60, 0);
      pitch = shifted(cur_cfg[CFG_PITCH_GESTURE_MAX], -60, 0);
      roll  = shifted(lo_lim, -60, -1);
      yaw   = shifted(hi_lim, 1, 60);
    end else if (g == 1) begin
      thr   = shifted(cur_cfg[CFG_THROTTLE_LOW_MAX], -60, 0);
      pitch = shifted(cur_cfg[CFG_PITCH_GESTURE_MAX], -60, 0);
      roll  = shifted(hi_lim, 1, 60);
      yaw   = shifted(lo_lim, -60, -1);
    end else begin
      thr   = any_chan(cur_cfg[CFG_THROTTLE_LOW_MAX]);
      pitch = any_chan(cur_cfg[CFG_PITCH_GESTURE_MAX]);
      roll  = any_chan($urandom_range(1) ? lo_lim : hi_lim);
      yaw   = any_chan($urandom_range(1) ? lo_lim : hi_lim);
    end
    aux1 = any_chan(cur_cfg[CFG_LAND_THRESHOLD]);
    aux2 = any_chan($urandom_range(1) ? cur_cfg[CFG_MODE_LOW_EDGE] : cur_cfg[CFG_MODE_HIGH_EDGE]);
    return {aux2, aux1, yaw, thr, pitch, roll};
  endfunction

  // offer one byte, with random sender gaps, and wait for the transaction
  task automatic put_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // build a frame from the sticks, spoil it as asked, and send it
  task automatic send_frame(input sticks_t ch, input flaw_t flaw);
    logic [7:0]  frm [FRAME_LENGTH];
    logic [15:0] sum;
    int          len;
    frm[0] = HEADER_0;
    frm[1] = HEADER_1;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      frm[2 + 2 * i] = ch[i][7:0];
      frm[3 + 2 * i] = ch[i][15:8];
    end
    for (int i = CH_END; i < FRAME_LENGTH - 2; i++) frm[i] = 8'($urandom());
    if (flaw == FLAW_HDR0) frm[0] = frm[0] ^ (8'h01 << $urandom_range(7));
    if (flaw == FLAW_HDR1) frm[1] = frm[1] ^ (8'h01 << $urandom_range(7));
    sum = '0;
    for (int i = 0; i < FRAME_LENGTH - 2; i++) sum = sum + {8'h00, frm[i]};
    sum = 16'hFFFF - sum;
    frm[FRAME_LENGTH - 2] = sum[7:0];
    frm[FRAME_LENGTH - 1] = sum[15:8];
    if (flaw == FLAW_SUM) begin
      len = FRAME_LENGTH - 2 + $urandom_range(1);
      frm[len] = frm[len] ^ (8'h01 << $urandom_range(7));
    end
    len = (flaw == FLAW_SHORT) ? $urandom_range(FRAME_LENGTH - 1, 1) : FRAME_LENGTH;
    for (int i = 0; i < len; i++) begin
      put_byte(frm[i], i == 0);
      frame_bytes++;
    end
  endtask

  // stop sending until every decoded frame has come out
  task automatic drain(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic apply_cfg(input limits_t v);
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= v[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = v;
  endtask

  initial begin : stimulus
    sticks_t center;
    limits_t cset;
    flaw_t   f;
    int      k;
    int      mark_bytes;
    int      mark_frames;
    center = {16'd1399, 16'd1801, 16'd1500, 16'd1500, 16'd1500, 16'd1500};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bytes before any start, clamps, gestures, each flight mode,
    // rejected frames, a short frame and trailing bytes
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    send_frame('0, FLAW_NONE);
    send_frame('1, FLAW_NONE);
    send_frame({16'd1400, 16'd1800, 16'd2000, 16'd1000, 16'd1500, 16'd1000}, FLAW_NONE);
    send_frame({16'd1600, 16'd1000, 16'd1000, 16'd1050, 16'd1950, 16'd2000}, FLAW_NONE);
    send_frame(center, FLAW_NONE);
    send_frame({16'd1599, 16'd1000, 16'd999, 16'd2001, 16'd1499, 16'd1501}, FLAW_NONE);
    send_frame(center, FLAW_HDR0);
    send_frame(center, FLAW_HDR1);
    send_frame(center, FLAW_SUM);
    send_frame(center, FLAW_SHORT);
    send_frame({16'd1400, 16'd1800, 16'd1751, 16'd999, 16'd1951, 16'd1249}, FLAW_NONE);
    repeat (3) put_byte(8'($urandom()), 1'b0);
    drain(4);

    // hold the result side off while frames keep coming, to back up the input
    hold_go <= 1'b1;
    repeat (5) send_frame(random_sticks(), FLAW_NONE);
    hold_go <= 1'b0;
    drain(4);

    // random frames over several threshold settings and idle mixes
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 2)
        0: begin src_idle_pct <= 32; snk_idle_pct <= 54; end
        1: begin src_idle_pct <= 54; snk_idle_pct <= 32; end
        default: begin src_idle_pct <= 0; snk_idle_pct <= 0; end
      endcase
      case (phase)
        1: cset = '0;
        3: cset = '1;
        4: begin
          // crossed stick limits and mode edges
          cset = LIMIT_DEFAULT;
          cset[CFG_STICK_LOW_LIMIT]  = 16'd1800;
          cset[CFG_STICK_HIGH_LIMIT] = 16'd1200;
          cset[CFG_MODE_LOW_EDGE]    = 16'd1700;
          cset[CFG_MODE_HIGH_EDGE]   = 16'd1300;
        end
        default: for (int i = 0; i < 7; i++) cset[i] = shifted(LIMIT_DEFAULT[i], -300, 300);
      endcase
      apply_cfg(cset);

      mark_bytes  = frame_bytes;
      mark_frames = whole_frames;
      while (frame_bytes - mark_bytes < BYTES_PER_PHASE || whole_frames - mark_frames < 3) begin
        k = $urandom_range(99);
        f = (k < 8)  ? FLAW_SUM :
            (k < 11) ? FLAW_HDR0 :
            (k < 14) ? FLAW_HDR1 :
            (k < 22) ? FLAW_SHORT : FLAW_NONE;
        send_frame(random_sticks(), f);
        if (f != FLAW_SHORT) begin
          whole_frames++;
          // stray bytes after a frame are dropped by the parser
          if ($urandom_range(99) < 15)
            repeat ($urandom_range(4, 1)) put_byte(8'($urandom()), 1'b0);
        end
      end
      drain(4);
    end

    drain(8);
    $display("covered %0d frame bytes, %0d decoded frames checked (%0d rejected)",
             frame_bytes, frames_checked, frames_rejected);
    $display("over default, random, all-zero, all-ones and crossed thresholds, three idle mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### rc_frame_decoder.f
src/rcfd_pkg.sv
src/rcfd_front.sv
src/rcfd_queue.sv
src/rcfd_back.sv
src/rc_frame_decoder.sv
src/rcfd_checker.sv
verif/rc_frame_checker.sv
verif/tb_top.sv
